// ----- rtl/ppi_pkg.sv -----
// Shared types, constants and microcode for the planar pose integrator.
// Holds the controller/datapath command and status structs and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package ppi_pkg;

  // Counter width covers the longest iterative operation (the divider).
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = 6;

  // Register indexes on the configuration port.
  localparam logic [7:0] REG_MODE   = 8'd0;
  localparam logic [7:0] REG_THRESH = 8'd1;

  // Integration mode codes.
  localparam logic [1:0] MODE_XY  = 2'd0;
  localparam logic [1:0] MODE_RK  = 2'd1;
  localparam logic [1:0] MODE_ARC = 2'd2;

  localparam logic [15:0] THRESH_RESET = 16'd684;

  // Fixed-point constants (Q2.30 where applicable).
  localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
  localparam logic signed [33:0] INV_HALF_PI_Q30 = 34'sd683565276;
  localparam logic signed [67:0] HALF_LSB30      = 68'sd536870912;
  localparam logic signed [35:0] ARC_LIMIT       = 36'sd8589934592;

  typedef enum logic [1:0] {PATH_XY = 2'd0, PATH_RK = 2'd1, PATH_ARC = 2'd2} path_t;
  typedef enum logic [1:0] {ANG_H0 = 2'd0, ANG_H1 = 2'd1, ANG_MID = 2'd2} ang_sel_t;
  typedef enum logic [1:0] {A_D = 2'd0, A_L = 2'd1, A_R = 2'd2, A_Q = 2'd3} a_sel_t;
  typedef enum logic [2:0] {
    B_C0 = 3'd0, B_S0 = 3'd1, B_DX = 3'd2, B_DY = 3'd3, B_K = 3'd4
  } b_sel_t;
  typedef enum logic [1:0] {
    ACC_LOAD = 2'd0, ACC_ADD = 2'd1, ACC_SUB = 2'd2, ACC_LOAD_Q2 = 2'd3
  } acc_op_t;
  typedef enum logic [2:0] {
    UOP_MUL = 3'd0, UOP_ACC = 3'd1, UOP_DIV = 3'd2, UOP_DELTA = 3'd3, UOP_END = 3'd4
  } uop_kind_t;
  typedef enum logic {DIV_QR = 1'b0, DIV_Q2 = 1'b1} div_dst_t;

  typedef struct packed {
    uop_kind_t kind;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    acc_op_t   acc_op;
    div_dst_t  div_dst;
    logic      dst_y;
    logic      use_lim;
  } uop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      cordic_init;
    ang_sel_t  ang_sel;
    logic      cordic_step;
    logic [4:0] step_idx;
    logic      cordic_save;
    logic      save_set;
    logic      mul;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    logic      acc;
    acc_op_t   acc_op;
    logic      div_init;
    logic      div_step;
    logic      div_fin;
    div_dst_t  div_dst;
    logic      delta;
    logic      delta_y;
    logic      use_lim;
    logic      commit;
  } ppi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    path_t path;
  } ppi_stat_t;

  function automatic uop_t mk_uop(uop_kind_t kind, a_sel_t a, b_sel_t b, acc_op_t op,
                                  div_dst_t dd, logic y, logic lim);
    uop_t u;
    u.kind    = kind;
    u.a_sel   = a;
    u.b_sel   = b;
    u.acc_op  = op;
    u.div_dst = dd;
    u.dst_y   = y;
    u.use_lim = lim;
    return u;
  endfunction

  // Arithmetic sequence for each integrator after sine and cosine are known.
  function automatic uop_t uop_rom(path_t path, logic [3:0] pc);
    uop_t u;
    u = mk_uop(UOP_END, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
    unique case (path)
      PATH_XY: begin
        case (pc)
          4'd0: u = mk_uop(UOP_MUL, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd1: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd2: u = mk_uop(UOP_MUL, A_L, B_S0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd3: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_SUB, DIV_QR, 1'b0, 1'b0);
          4'd4: u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd5: u = mk_uop(UOP_MUL, A_D, B_S0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd6: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd7: u = mk_uop(UOP_MUL, A_L, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd8: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_ADD, DIV_QR, 1'b0, 1'b0);
          4'd9: u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b1, 1'b0);
          default: ;
        endcase
      end
      PATH_ARC: begin
        case (pc)
          4'd0:  u = mk_uop(UOP_MUL, A_D, B_DX, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd1:  u = mk_uop(UOP_DIV, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd2:  u = mk_uop(UOP_MUL, A_R, B_K, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd3:  u = mk_uop(UOP_DIV, A_D, B_C0, ACC_LOAD, DIV_Q2, 1'b0, 1'b0);
          4'd4:  u = mk_uop(UOP_MUL, A_Q, B_K, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd5:  u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD_Q2, DIV_QR, 1'b0, 1'b0);
          4'd6:  u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b1);
          4'd7:  u = mk_uop(UOP_MUL, A_D, B_DY, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd8:  u = mk_uop(UOP_DIV, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd9:  u = mk_uop(UOP_MUL, A_R, B_K, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd10: u = mk_uop(UOP_DIV, A_D, B_C0, ACC_LOAD, DIV_Q2, 1'b0, 1'b0);
          4'd11: u = mk_uop(UOP_MUL, A_Q, B_K, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd12: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD_Q2, DIV_QR, 1'b0, 1'b0);
          4'd13: u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b1, 1'b1);
          default: ;
        endcase
      end
      default: begin
        // Runge-Kutta, also taken for the unused mode code.
        case (pc)
          4'd0: u = mk_uop(UOP_MUL, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd1: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd2: u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd3: u = mk_uop(UOP_MUL, A_D, B_S0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd4: u = mk_uop(UOP_ACC, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b0, 1'b0);
          4'd5: u = mk_uop(UOP_DELTA, A_D, B_C0, ACC_LOAD, DIV_QR, 1'b1, 1'b0);
          default: ;
        endcase
      end
    endcase
    return u;
  endfunction

  // CORDIC arctangent table, binary angle units.
  function automatic logic signed [33:0] atan_q(logic [4:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/ppi_if.sv -----
// Valid/ready channel interfaces of the planar pose integrator.
// Input request, result and configuration write channels; no dependencies.
`timescale 1ns / 1ps

interface ppi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dist_forward;
  logic signed [31:0] dist_lateral;
  logic signed [31:0] delta_heading;
  modport source(output valid, dist_forward, dist_lateral, delta_heading, input ready);
  modport sink(input valid, dist_forward, dist_lateral, delta_heading, output ready);
endinterface

interface ppi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading_out;
  logic               saturated;
  modport source(output valid, pos_x, pos_y, heading_out, saturated, input ready);
  modport sink(input valid, pos_x, pos_y, heading_out, saturated, output ready);
endinterface

interface ppi_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/ppi_ctrl.sv -----
// Sequencing controller: handshakes, CORDIC and divider step counts, microcode walk.
// Depends on ppi_pkg.
`timescale 1ns / 1ps

module ppi_ctrl #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ppi_pkg::ppi_stat_t  stat,
  output ppi_pkg::ppi_cmd_t   cmd
);
  import ppi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CINIT  = 8'b0000_0010,
    S_CSTEP  = 8'b0000_0100,
    S_CSAVE  = 8'b0000_1000,
    S_EXEC   = 8'b0001_0000,
    S_DSTEP  = 8'b0010_0000,
    S_DFIN   = 8'b0100_0000,
    S_COMMIT = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       pc_r, pc_nxt;
  logic             phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  uop_t             uop;

  assign uop       = uop_rom(stat.path, pc_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.step_idx  = cnt_r[4:0];
    cmd.save_set  = phase_r;
    cmd.a_sel     = uop.a_sel;
    cmd.b_sel     = uop.b_sel;
    cmd.acc_op    = uop.acc_op;
    cmd.div_dst   = uop.div_dst;
    cmd.delta_y   = uop.dst_y;
    cmd.use_lim   = uop.use_lim;
    if (stat.path == PATH_RK) begin
      cmd.ang_sel = ANG_MID;
    end else if (phase_r) begin
      cmd.ang_sel = ANG_H1;
    end else begin
      cmd.ang_sel = ANG_H0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          phase_nxt = 1'b0;
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_CSAVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CSAVE: begin
        cmd.cordic_save = 1'b1;
        if (stat.path == PATH_ARC && !phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_CINIT;
        end else begin
          pc_nxt    = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (uop.kind)
          UOP_MUL: begin
            cmd.mul = 1'b1;
            pc_nxt  = pc_r + 1'b1;
          end
          UOP_ACC: begin
            cmd.acc = 1'b1;
            pc_nxt  = pc_r + 1'b1;
          end
          UOP_DELTA: begin
            cmd.delta = 1'b1;
            pc_nxt    = pc_r + 1'b1;
          end
          UOP_DIV: begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DSTEP;
          end
          default: state_nxt = S_COMMIT;
        endcase
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DFIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        pc_nxt      = pc_r + 1'b1;
        state_nxt   = S_EXEC;
      end
      S_COMMIT: begin
        // Wait until the result register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pc_r        <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ppi_datapath.sv -----
// Datapath: pose and configuration registers, iterative CORDIC, shared multiplier,
// accumulator, bit-serial signed divider and saturating pose update. Depends on ppi_pkg.
`timescale 1ns / 1ps

module ppi_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ppi_pkg::ppi_cmd_t  cmd,
  output ppi_pkg::ppi_stat_t stat,
  input  logic signed [31:0] dist_forward,
  input  logic signed [31:0] dist_lateral,
  input  logic signed [31:0] delta_heading,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading_out,
  output logic               saturated
);
  import ppi_pkg::*;

  // Configuration and pose state.
  logic [1:0]         mode_r;
  logic [15:0]        thresh_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic [31:0]        acc_heading_r;
  logic               sat_r;

  // Request operands.
  logic signed [31:0] d_r, l_r, w_r;

  // CORDIC and saved sine/cosine.
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [31:0] c0_r, s0_r, c1_r, s1_r;

  // Multiplier, accumulator, divider and deltas.
  logic signed [67:0] prod_r, acc_r;
  logic [63:0]        quo_r;
  logic [31:0]        rem_r;
  logic               dneg_r;
  logic signed [33:0] q_r;
  logic signed [32:0] r_r;
  logic signed [31:0] q2_r;
  logic               lim_r, lim_neg_r;
  logic signed [35:0] dx_r, dy_r;

  logic [31:0]        wmag, h1, ang, ang_f;
  logic               flip;
  logic signed [33:0] xs, ys, atan_v, a_op, b_op, cxf, cyf;
  logic signed [67:0] pmag, rnd, shifted;
  logic [32:0]        trial;
  logic               ge, qneg;
  logic signed [33:0] qmag;
  logic signed [35:0] dval;
  logic signed [36:0] sx, sy;
  logic               ovx, ovy;

  // Path selection from the mode and the heading change.
  assign wmag = w_r[31] ? (~w_r + 32'd1) : w_r;
  always_comb begin
    if (mode_r == MODE_XY) begin
      stat.path = PATH_XY;
    end else if (mode_r == MODE_ARC && w_r != 32'sd0 && wmag >= {16'd0, thresh_r}) begin
      stat.path = PATH_ARC;
    end else begin
      stat.path = PATH_RK;
    end
  end

  // CORDIC angle pick and half-turn fold.
  assign h1 = acc_heading_r + w_r;
  always_comb begin
    unique case (cmd.ang_sel)
      ANG_H1:  ang = h1;
      ANG_MID: ang = acc_heading_r + {w_r[31], w_r[31:1]};
      default: ang = acc_heading_r;
    endcase
  end
  assign flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_f  = flip ? (ang ^ 32'h8000_0000) : ang;
  assign xs     = cx_r >>> cmd.step_idx;
  assign ys     = cy_r >>> cmd.step_idx;
  assign atan_v = atan_q(cmd.step_idx);
  assign cxf    = flip_r ? -cx_r : cx_r;
  assign cyf    = flip_r ? -cy_r : cy_r;

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd.a_sel)
      A_L:     a_op = 34'(l_r);
      A_R:     a_op = 34'(r_r);
      A_Q:     a_op = q_r;
      default: a_op = 34'(d_r);
    endcase
    unique case (cmd.b_sel)
      B_S0:    b_op = 34'(s0_r);
      B_DX:    b_op = 34'(s1_r) - 34'(s0_r);
      B_DY:    b_op = 34'(c0_r) - 34'(c1_r);
      B_K:     b_op = INV_HALF_PI_Q30;
      default: b_op = 34'(c0_r);
    endcase
  end

  // Divider step and result signs.
  assign pmag  = prod_r[67] ? -prod_r : prod_r;
  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, wmag};
  assign qneg  = dneg_r ^ w_r[31];
  assign qmag  = {1'b0, quo_r[32:0]};

  // Rounding to the position format, with the arc quotient limit.
  assign rnd     = acc_r + HALF_LSB30;
  assign shifted = rnd >>> 30;
  always_comb begin
    if (cmd.use_lim && lim_r) begin
      dval = lim_neg_r ? -ARC_LIMIT : ARC_LIMIT;
    end else begin
      dval = shifted[35:0];
    end
  end

  // Saturating position update.
  assign sx  = 37'(acc_x_r) + 37'(dx_r);
  assign sy  = 37'(acc_y_r) + 37'(dy_r);
  assign ovx = sx[36:31] != {6{sx[36]}};
  assign ovy = sy[36:31] != {6{sy[36]}};

  // Configuration and pose registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RK;
      thresh_r      <= THRESH_RESET;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      acc_heading_r <= '0;
      sat_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) begin
          mode_r <= cfg_data[1:0];
        end else if (cfg_index == REG_THRESH) begin
          thresh_r <= cfg_data[15:0];
        end
      end
      if (cmd.commit) begin
        acc_x_r       <= ovx ? (sx[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sx[31:0];
        acc_y_r       <= ovy ? (sy[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sy[31:0];
        acc_heading_r <= h1;
        sat_r         <= ovx | ovy;
      end
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r <= dist_forward;
      l_r <= dist_lateral;
      w_r <= delta_heading;
    end
    if (cmd.cordic_init) begin
      cx_r   <= CORDIC_GAIN;
      cy_r   <= '0;
      cz_r   <= 34'(signed'(ang_f));
      flip_r <= flip;
    end
    if (cmd.cordic_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_v;
      end
    end
    if (cmd.cordic_save) begin
      if (cmd.save_set) begin
        c1_r <= cxf[31:0];
        s1_r <= cyf[31:0];
      end else begin
        c0_r <= cxf[31:0];
        s0_r <= cyf[31:0];
      end
    end
    if (cmd.mul) begin
      prod_r <= a_op * b_op;
    end
    if (cmd.acc) begin
      unique case (cmd.acc_op)
        ACC_ADD:     acc_r <= acc_r + prod_r;
        ACC_SUB:     acc_r <= acc_r - prod_r;
        ACC_LOAD_Q2: acc_r <= prod_r + 68'(q2_r);
        default:     acc_r <= prod_r;
      endcase
    end
    if (cmd.div_init) begin
      quo_r  <= pmag[63:0];
      rem_r  <= '0;
      dneg_r <= prod_r[67];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 32'(trial - {1'b0, wmag}) : trial[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
    if (cmd.div_fin) begin
      if (cmd.div_dst == DIV_QR) begin
        lim_r     <= |quo_r[63:33];
        lim_neg_r <= qneg;
        q_r       <= qneg ? -qmag : qmag;
        r_r       <= dneg_r ? -{1'b0, rem_r} : {1'b0, rem_r};
      end else begin
        q2_r <= qneg ? -quo_r[31:0] : quo_r[31:0];
      end
    end
    if (cmd.delta) begin
      if (cmd.delta_y) begin
        dy_r <= dval;
      end else begin
        dx_r <= dval;
      end
    end
  end

  assign pos_x       = acc_x_r;
  assign pos_y       = acc_y_r;
  assign heading_out = acc_heading_r;
  assign saturated   = sat_r;

endmodule

// ----- rtl/planar_pose_integrator.sv -----
// Exact arc mode makes two sine/cosine evaluations and four 64-step divisions per request.
// One request at a time: the next is taken in the cycle the result becomes valid; while the
// result side stalls, the next request waits before its commit.
// Reset clears x, y and heading to zero, mode to Runge-Kutta and the threshold to 684.
// Top level: controller plus datapath; depends on ppi_pkg, ppi_if, ppi_ctrl, ppi_datapath.
`timescale 1ns / 1ps

module planar_pose_integrator #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  ppi_in_if.sink   in_ch,
  ppi_out_if.source out_ch,
  ppi_cfg_if.sink  cfg_ch
);
  import ppi_pkg::*;

  ppi_cmd_t  cmd;
  ppi_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  ppi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppi_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .dist_forward (in_ch.dist_forward),
    .dist_lateral (in_ch.dist_lateral),
    .delta_heading(in_ch.delta_heading),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .pos_x        (out_ch.pos_x),
    .pos_y        (out_ch.pos_y),
    .heading_out  (out_ch.heading_out),
    .saturated    (out_ch.saturated)
  );

endmodule

// ----- verif/planar_pose_integrator_tb.sv -----
// Self-checking testbench for the planar pose integrator: directed table, then random requests.
// Predicts each pose with an in-bench fixed-point model and checks every result field.
// Depends on ppi_pkg, ppi_if and the planar_pose_integrator RTL.
`timescale 1ns / 1ps

module planar_pose_integrator_tb;
  import ppi_pkg::*;

  localparam int unsigned STEPS      = 24;
  localparam longint      CYCLE_CAP  = 3000000;
  localparam int          RAND_ITEMS = 1330;
  localparam longint      K_Q30      = 64'sd683565276;
  localparam longint      ARC_CAP    = 64'sd8589934592;
  localparam longint      HALF_Q30   = 64'sd536870912;

  typedef struct {
    logic signed [31:0] fwd;
    logic signed [31:0] lat;
    logic signed [31:0] dh;
  } step_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        h;
    logic               sat;
  } pose_t;

  // One directed row: optional register write before the request, optional typed-in pose.
  typedef struct {
    logic        do_cfg;
    logic [7:0]  cfg_idx;
    logic [31:0] cfg_val;
    step_req_t   req;
    logic        fixed;
    pose_t       pose;
  } dir_row_t;

  logic clk;
  logic rst_n;
  ppi_in_if  in_ch();
  ppi_out_if out_ch();
  ppi_cfg_if cfg_ch();

  planar_pose_integrator #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state and configuration shadow.
  logic [1:0]  mode_q;
  logic [15:0] thresh_q;
  longint      px_q;
  longint      py_q;
  logic [31:0] ph_q;

  pose_t  pose_queue[$];
  int     err_cnt;
  int     sent_cnt;
  int     got_cnt;
  int     sat_cnt;
  int     arc_cnt;
  longint cyc;
  logic   in_idle_on;
  logic   out_idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Global cycle watchdog.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd30(longint v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  // Rotation-mode CORDIC giving Q2.30 cosine and sine of a binary angle.
  task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint xx;
    longint yy;
    longint zz;
    longint xs;
    longint ys;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h8000_0000;
    xx = 652032874;
    yy = 0;
    zz = longint'($signed(ang));
    for (int i = 0; i < STEPS; i++) begin
      xs = fshift(xx, i);
      ys = fshift(yy, i);
      if (zz >= 0) begin
        xx = xx - ys; yy = yy + xs; zz = zz - longint'(atan_q(i[4:0]));
      end else begin
        xx = xx + ys; yy = yy - xs; zz = zz + longint'(atan_q(i[4:0]));
      end
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endtask

  // Chord displacement of an arc step, clamped when the quotient is huge.
  function automatic longint arc_step(longint d, longint diff, longint w);
    longint t;
    longint q;
    longint r;
    t = d * diff;
    q = t / w;
    r = t % w;
    if (q >= ARC_CAP) return ARC_CAP;
    if (q <= -ARC_CAP) return -ARC_CAP;
    return (q * K_Q30 + (r * K_Q30) / w + HALF_Q30) >>> 30;
  endfunction

  function automatic longint clip32(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin flag = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin flag = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  // Advance the predicted pose by one request and return the new pose.
  task automatic integrate_step(input step_req_t r, output pose_t p);
    longint      d;
    longint      l;
    longint      w;
    longint      mag;
    longint      dx;
    longint      dy;
    longint      c0;
    longint      s0;
    longint      c1;
    longint      s1;
    logic [31:0] h1;
    logic [31:0] mid;
    logic        sat;
    d = r.fwd;
    l = r.lat;
    w = r.dh;
    h1 = ph_q + r.dh;
    mag = (w < 0) ? -w : w;
    sat = 1'b0;
    if (mode_q == MODE_XY) begin
      cordic(ph_q, c0, s0);
      dx = rnd30(d * c0 - l * s0);
      dy = rnd30(d * s0 + l * c0);
    end else if (mode_q == MODE_ARC && w != 0 && mag >= longint'(thresh_q)) begin
      cordic(ph_q, c0, s0);
      cordic(h1, c1, s1);
      dx = arc_step(d, s1 - s0, w);
      dy = arc_step(d, c0 - c1, w);
      arc_cnt++;
    end else begin
      mid = ph_q + 32'(w >>> 1);
      cordic(mid, c0, s0);
      dx = rnd30(d * c0);
      dy = rnd30(d * s0);
    end
    px_q = clip32(px_q + dx, sat);
    py_q = clip32(py_q + dy, sat);
    ph_q = h1;
    p.x = px_q[31:0];
    p.y = py_q[31:0];
    p.h = ph_q;
    p.sat = sat;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch %s at result %0d: got %h expected %h", what, got_cnt, got, want);
  endtask

  // Random stalls on the result side.
  initial begin
    int burst;
    out_ch.ready <= 1'b0;
    out_idle_on = 1'b1;
    @(posedge clk);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result against the oldest predicted pose.
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pose_queue.size() == 0) begin
        err_cnt++;
        $display("unexpected result %h %h %h", out_ch.pos_x, out_ch.pos_y, out_ch.heading_out);
      end else begin
        e = pose_queue.pop_front();
        if (out_ch.pos_x !== e.x) report_mismatch("pos_x", out_ch.pos_x, e.x);
        if (out_ch.pos_y !== e.y) report_mismatch("pos_y", out_ch.pos_y, e.y);
        if (out_ch.heading_out !== e.h) report_mismatch("heading", out_ch.heading_out, e.h);
        if (out_ch.saturated !== e.sat) report_mismatch("saturated", out_ch.saturated, e.sat);
        if (e.sat) sat_cnt++;
      end
      got_cnt++;
    end
  end

  // Write one register; valid is dropped again before the task returns.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MODE) mode_q = val[1:0];
    else if (idx == REG_THRESH) thresh_q = val[15:0];
  endtask

  // Drop the input request, wait for every outstanding result, then let the block settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Send one request; optionally queue a typed-in pose instead of the predicted one.
  // Valid stays high after acceptance until the next request, an idle gap or a drain.
  task automatic send_step(input step_req_t r, input logic fixed, input pose_t want);
    pose_t p;
    int    gap;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.dist_forward  <= r.fwd;
    in_ch.dist_lateral  <= r.lat;
    in_ch.delta_heading <= r.dh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    integrate_step(r, p);
    pose_queue.push_back(fixed ? want : p);
    sent_cnt++;
  endtask

  function automatic logic [31:0] rand_field(int kind);
    case (kind)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
      3: return $urandom() >>> $urandom_range(0, 16);
      default: return $urandom();
    endcase
  endfunction

  dir_row_t dir_tab[$];

  function automatic dir_row_t row(logic c, logic [7:0] i, logic [31:0] v,
                                   logic [31:0] f, logic [31:0] l, logic [31:0] h);
    dir_row_t rr;
    rr.do_cfg = c;
    rr.cfg_idx = i;
    rr.cfg_val = v;
    rr.req.fwd = f;
    rr.req.lat = l;
    rr.req.dh = h;
    rr.fixed = 1'b0;
    rr.pose = '{0, 0, 0, 0};
    return rr;
  endfunction

  initial begin
    step_req_t r;
    pose_t     none;
    dir_row_t  rr;
    int        phase;
    rst_n = 1'b0;
    cyc = 0;
    err_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    sat_cnt = 0;
    arc_cnt = 0;
    in_idle_on = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.dist_forward <= '0;
    in_ch.dist_lateral <= '0;
    in_ch.delta_heading <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_MODE;
    cfg_ch.data <= '0;
    none = '{0, 0, 0, 0};
    mode_q = MODE_RK;
    thresh_q = THRESH_RESET;
    px_q = 0;
    py_q = 0;
    ph_q = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset defaults, extremes, each mode, arc special cases.
    rr = row(0, REG_MODE, 0, 32'h0001_0000, 0, 0);
    rr.fixed = 1; rr.pose = '{32'h0001_0000, 0, 0, 0};
    dir_tab.push_back(rr);
    rr = row(0, REG_MODE, 0, 0, 0, 32'h4000_0000);
    rr.fixed = 1; rr.pose = '{32'h0001_0000, 0, 32'h4000_0000, 0};
    dir_tab.push_back(rr);
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    dir_tab.push_back(row(1, REG_MODE, MODE_XY, 32'h0003_0000, 32'hFFFE_0000, 32'h1234_5678));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    dir_tab.push_back(row(1, REG_MODE, MODE_ARC, 32'h0010_0000, 0, 32'h1000_0000));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h0010_0000, 0, 0));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h0010_0000, 0, 683));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h0010_0000, 0, 684));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h7FFF_FFFF, 0, 1000));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h8000_0000, 0, -1000));
    dir_tab.push_back(row(1, REG_THRESH, 0, 32'h0001_0000, 0, 1));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h0001_0000, 0, 0));
    dir_tab.push_back(row(1, REG_THRESH, 32'hFFFF_FFFF, 32'h0005_0000, 0, 65534));
    dir_tab.push_back(row(0, REG_MODE, 0, 32'h0005_0000, 0, 32'h8000_0000));
    dir_tab.push_back(row(1, REG_MODE, 3, 32'h0002_0000, 32'h7FFF_FFFF, 32'h2000_0000));
    dir_tab.push_back(row(1, 8'd7, 32'h1, 32'hFFFF_0000, 0, 32'hE000_0000));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].do_cfg) begin
        drain();
        write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      end
      send_step(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].pose);
    end

    // Random phases across modes and thresholds; the last phase runs without idling.
    for (phase = 0; phase < 10; phase++) begin
      drain();
      write_reg(REG_MODE, (phase == 9) ? MODE_ARC : $urandom_range(0, 3));
      write_reg(REG_THRESH, (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 16'hFFFF
                                                 : $urandom_range(0, 4000));
      if (phase == 9) in_idle_on = 1'b0;
      if (phase == 9) out_idle_on = 1'b0;
      for (int k = 0; k < RAND_ITEMS / 10; k++) begin
        r.fwd = rand_field($urandom_range(0, 9) < 1 ? $urandom_range(0, 1)
                                                      : $urandom_range(2, 4));
        r.lat = rand_field($urandom_range(0, 9) < 1 ? $urandom_range(0, 1)
                                                      : $urandom_range(2, 4));
        case ($urandom_range(0, 5))
          0: r.dh = $urandom_range(0, 8000) - 4000;
          1: r.dh = 0;
          default: r.dh = rand_field($urandom_range(0, 4));
        endcase
        send_step(r, 1'b0, none);
      end
    end

    drain();
    repeat (400) @(posedge clk);
    $display("Covered %0d requests, %0d results, %0d arc steps, %0d saturated.",
             sent_cnt, got_cnt, arc_cnt, sat_cnt);
    if (err_cnt == 0 && pose_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
